@@ design/dcrb_pkg.sv @@
package dcrb_pkg;

    localparam int NUM_CHANNELS_DEF = 7;

    localparam int FUNC_W    = 2;
    localparam int CHANNEL_W = 3;
    localparam int SEL_W     = 2;
    localparam int DATA_W    = 32;

    // Bus function codes
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DONE  = 2'd2;

    // Register select codes
    localparam logic [SEL_W-1:0] SEL_BASE  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_BLOCK = 2'd1;
    localparam logic [SEL_W-1:0] SEL_CTRL  = 2'd2;

    // Sync modes
    localparam logic [1:0] SYNC_MANUAL   = 2'd0;
    localparam logic [1:0] SYNC_REQUEST  = 2'd1;
    localparam logic [1:0] SYNC_LINKED   = 2'd2;
    localparam logic [1:0] SYNC_RESERVED = 2'd3;

    localparam int BASE_W = 24;

    // One channel's registers, as held in the channel store
    typedef struct packed {
        logic [1:0]        spare;
        logic              trigger;
        logic              enable;
        logic [2:0]        cpu_window;
        logic [2:0]        dma_window;
        logic [1:0]        sync_mode;
        logic              chop;
        logic              step_dec;
        logic              dir_from_ram;
        logic [BASE_W-1:0] base;
        logic [15:0]       block_size;
        logic [15:0]       block_count;
    } chan_entry_t;

    // Request as packed on the slave stream, func in the lowest bits
    typedef struct packed {
        logic [DATA_W-1:0]    write_data;
        logic [SEL_W-1:0]     reg_select;
        logic [CHANNEL_W-1:0] channel;
        logic [FUNC_W-1:0]    func;
    } request_t;

    // Outcome of one register access
    typedef struct packed {
        logic              wr_en;
        logic              sync_err;
        logic [DATA_W-1:0] rd_data;
    } update_t;

endpackage

@@ design/dcrb_store.sv @@
module dcrb_store #(
    parameter int NUM_CHANNELS = dcrb_pkg::NUM_CHANNELS_DEF,
    parameter int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output dcrb_pkg::chan_entry_t rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  dcrb_pkg::chan_entry_t wr_data
);
    import dcrb_pkg::*;

    chan_entry_t              mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  valid_reg;
    chan_entry_t              rd_entry_reg;
    logic                     rd_valid_reg;

    // Entries never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_entry_reg : '0;

endmodule

@@ design/dcrb_update.sv @@
module dcrb_update (
    input  dcrb_pkg::request_t    req,
    input  dcrb_pkg::chan_entry_t old_entry,
    output dcrb_pkg::chan_entry_t new_entry,
    output dcrb_pkg::update_t     upd
);
    import dcrb_pkg::*;

    logic [1:0] wr_sync;

    assign wr_sync = req.write_data[10:9];

    always_comb
    begin
        new_entry    = old_entry;
        upd.wr_en    = 1'b0;
        upd.sync_err = 1'b0;
        upd.rd_data  = '0;
        unique case (req.func)
            FUNC_READ:
            begin
                unique case (req.reg_select)
                    SEL_BASE:  upd.rd_data = {8'd0, old_entry.base};
                    SEL_BLOCK: upd.rd_data = {old_entry.block_count, old_entry.block_size};
                    SEL_CTRL:
                    begin
                        upd.rd_data[0]     = old_entry.dir_from_ram;
                        upd.rd_data[1]     = old_entry.step_dec;
                        upd.rd_data[8]     = old_entry.chop;
                        upd.rd_data[10:9]  = old_entry.sync_mode;
                        upd.rd_data[18:16] = old_entry.dma_window;
                        upd.rd_data[22:20] = old_entry.cpu_window;
                        upd.rd_data[24]    = old_entry.enable;
                        upd.rd_data[28]    = old_entry.trigger;
                        upd.rd_data[30:29] = old_entry.spare;
                    end
                    default: upd.rd_data = '0;
                endcase
            end
            FUNC_WRITE:
            begin
                unique case (req.reg_select)
                    SEL_BASE:
                    begin
                        new_entry.base = req.write_data[BASE_W-1:0];
                        upd.wr_en      = 1'b1;
                    end
                    SEL_BLOCK:
                    begin
                        new_entry.block_size  = req.write_data[15:0];
                        new_entry.block_count = req.write_data[31:16];
                        upd.wr_en             = 1'b1;
                    end
                    SEL_CTRL:
                    begin
                        // Drop a write that carries the reserved sync mode
                        if (wr_sync == SYNC_RESERVED)
                        begin
                            upd.sync_err = 1'b1;
                        end
                        else
                        begin
                            new_entry.dir_from_ram = req.write_data[0];
                            new_entry.step_dec     = req.write_data[1];
                            new_entry.chop         = req.write_data[8];
                            new_entry.sync_mode    = wr_sync;
                            new_entry.dma_window   = req.write_data[18:16];
                            new_entry.cpu_window   = req.write_data[22:20];
                            new_entry.enable       = req.write_data[24];
                            new_entry.trigger      = req.write_data[28];
                            new_entry.spare        = req.write_data[30:29];
                            upd.wr_en              = 1'b1;
                        end
                    end
                    default: upd.wr_en = 1'b0;
                endcase
            end
            FUNC_DONE:
            begin
                new_entry.enable  = 1'b0;
                new_entry.trigger = 1'b0;
                upd.wr_en         = 1'b1;
            end
            default: upd.wr_en = 1'b0;
        endcase
    end

endmodule

@@ design/dma_channel_register_bank_core.sv @@
// DMA channel register bank.
// Input stream (s_axis_*): one register request per transfer, carrying the
// function (read, write, mark done), channel, register select and write data.
// Output stream (m_axis_*): one response per request with the read data, the
// channel's active flag, its transfer size, a linked-list flag and a flag for
// a control write dropped because of the reserved sync mode.
// The channel registers live in a synchronous memory of NUM_CHANNELS entries.
// A request reads its entry on acceptance, modifies and writes it back in
// ST_UPDATE, then computes the transfer size through a 16x16 multiplier into
// the output register in ST_EMIT. No new request is taken until the previous
// one has loaded the output register, because of the memory read-modify-write
// loop: one request is in flight at a time.
// The output register decouples the sides: a request is accepted while the
// previous response still waits; when the receiver stalls the request in
// flight holds in its last stage until the response register frees up.
// Reset clears the per-entry valid bits, so every channel reads as zero,
// and empties the pipeline; no clearing sweep is needed.
// Requests naming a channel at or beyond NUM_CHANNELS change nothing and
// respond with all fields zero.
module dma_channel_register_bank_core #(
    parameter int NUM_CHANNELS = dcrb_pkg::NUM_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata, from bit 0: func[2], channel[3], reg_select[2],
    // write_data[32], zero fill[1]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    // m_axis_tdata, from bit 0: read_data[32], active[1], transfer_size[32],
    // size_unknown[1], sync_error[1], zero fill[5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata
);
    import dcrb_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    state_t       state_reg;
    request_t     in_req;
    request_t     req_reg;
    logic         in_accept;
    logic         in_range;
    logic         in_range_reg;
    chan_entry_t  old_entry;
    chan_entry_t  new_entry;
    chan_entry_t  entry_reg;
    update_t      upd;
    logic [31:0]  rd_data_reg;
    logic         sync_err_reg;
    logic         out_load;
    logic [31:0]  product;

    logic         out_valid_reg;
    logic [31:0]  out_read_data_reg;
    logic         out_active_reg;
    logic [31:0]  out_size_reg;
    logic         out_unknown_reg;
    logic         out_err_reg;

    assign in_req = s_axis_tdata[38:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_range      = 32'(req_reg.channel) < NUM_CHANNELS;

    dcrb_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AW           (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (AW'(in_req.channel)),
        .rd_data (old_entry),
        .wr_en   ((state_reg == ST_UPDATE) && in_range && upd.wr_en),
        .wr_addr (AW'(req_reg.channel)),
        .wr_data (new_entry)
    );

    dcrb_update u_update (
        .req       (req_reg),
        .old_entry (old_entry),
        .new_entry (new_entry),
        .upd       (upd)
    );

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);
    assign product  = {16'd0, entry_reg.block_size} * {16'd0, entry_reg.block_count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            req_reg           <= '0;
            in_range_reg      <= 1'b0;
            entry_reg         <= '0;
            rd_data_reg       <= '0;
            sync_err_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_read_data_reg <= '0;
            out_active_reg    <= 1'b0;
            out_size_reg      <= '0;
            out_unknown_reg   <= 1'b0;
            out_err_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    // Memory read issues on the accept edge
                    if (in_accept)
                    begin
                        req_reg   <= in_req;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    // Write back and hold the updated entry for the status stage
                    in_range_reg <= in_range;
                    entry_reg    <= new_entry;
                    rd_data_reg  <= upd.rd_data;
                    sync_err_reg <= upd.sync_err;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_read_data_reg <= in_range_reg ? rd_data_reg : '0;
                        out_err_reg       <= in_range_reg && sync_err_reg;
                        out_active_reg    <= in_range_reg && entry_reg.enable
                                             && (entry_reg.sync_mode != SYNC_MANUAL
                                                 || entry_reg.trigger);
                        out_unknown_reg   <= in_range_reg
                                             && (entry_reg.sync_mode == SYNC_LINKED);
                        if (!in_range_reg)
                        begin
                            out_size_reg <= '0;
                        end
                        else if (entry_reg.sync_mode == SYNC_MANUAL)
                        begin
                            out_size_reg <= {16'd0, entry_reg.block_size};
                        end
                        else if (entry_reg.sync_mode == SYNC_REQUEST)
                        begin
                            out_size_reg <= product;
                        end
                        else
                        begin
                            out_size_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_err_reg, out_unknown_reg, out_size_reg,
                            out_active_reg, out_read_data_reg};

    // Entry update only follows an accepted request
    a_update_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("update stage entered without an accepted request");

    // Linked-list mode reports a zero size
    a_unknown_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_unknown_reg |-> out_size_reg == '0)
        else $error("size reported in linked-list mode");

    // A dropped control write returns no read data
    a_err_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_read_data_reg == '0)
        else $error("sync error response carries read data");

    // A new response is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_size_reg))
        else $error("pending response lost");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for the DMA channel register bank.
// Requests (read, write, mark done) are queued up front by the stimulus block,
// pushed into the slave stream by a clocked driver, and predicted on acceptance
// by a scoreboard model of the seven channel register sets. Every response on
// the master stream is compared field by field with the oldest prediction.
module tb_top;

    import dcrb_pkg::*;

    localparam int NUM_CH = NUM_CHANNELS_DEF;

    // Codes the package leaves unnamed: accepted by the bus, act on nothing
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [SEL_W-1:0]  SEL_UNUSED  = 2'd3;

    localparam int RANDOM_REQUESTS = 1450;
    localparam int DRAIN_CYCLES    = 12;

    // Idle pattern of both stream sides, carried along with each request
    typedef enum logic [1:0] {
        MODE_STEADY,
        MODE_SRC_IDLE,
        MODE_SINK_STALL,
        MODE_BOTH
    } idle_mode_t;

    // Slave stream payload, highest field first
    typedef struct packed {
        logic                 fill;
        logic [DATA_W-1:0]    write_data;
        logic [SEL_W-1:0]     reg_select;
        logic [CHANNEL_W-1:0] channel;
        logic [FUNC_W-1:0]    func;
    } bus_req_t;

    // Master stream payload, highest field first
    typedef struct packed {
        logic [4:0]  fill;
        logic        sync_error;
        logic        size_unknown;
        logic [31:0] transfer_size;
        logic        active;
        logic [31:0] read_data;
    } bus_resp_t;

    typedef struct packed {
        idle_mode_t mode;
        bus_req_t   req;
    } pending_req_t;

    // Scoreboard copy of one channel's registers
    typedef struct packed {
        logic        dir_from_ram;
        logic        step_dec;
        logic        chop;
        logic [1:0]  sync_mode;
        logic [2:0]  dma_window;
        logic [2:0]  cpu_window;
        logic        enable;
        logic        trigger;
        logic [1:0]  spare;
        logic [23:0] base;
        logic [15:0] block_size;
        logic [15:0] block_count;
    } chan_regs_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    bus_req_t    s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    // Set at the edge that took a request, so the driver advances at the next fall
    logic        req_fire = 1'b0;
    idle_mode_t  cur_mode = MODE_STEADY;

    pending_req_t pending_reqs[$];
    bus_resp_t    resp_expected[$];
    chan_regs_t   chan_regs[NUM_CH];

    int n_errors = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_done = 0;
    int n_other = 0;
    int n_sync_err = 0;
    int n_out_of_range = 0;
    int n_responses = 0;

    dma_channel_register_bank_core #(
        .NUM_CHANNELS(NUM_CH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Apply one access to the register copy and return the response it causes.
    // Status fields are taken after the access, as the hardware reports them.
    function automatic bus_resp_t apply_access(input bus_req_t r);
        bus_resp_t  o;
        chan_regs_t c;
        logic [1:0] sm;
        o = '0;
        if (r.channel >= NUM_CH)
            return o;
        c = chan_regs[r.channel];
        case (r.func)
            FUNC_READ:
                case (r.reg_select)
                    SEL_BASE:  o.read_data = {8'h00, c.base};
                    SEL_BLOCK: o.read_data = {c.block_count, c.block_size};
                    SEL_CTRL:  o.read_data = {1'b0, c.spare, c.trigger, 3'b000, c.enable,
                                              1'b0, c.cpu_window, 1'b0, c.dma_window,
                                              5'b00000, c.sync_mode, c.chop, 6'b000000,
                                              c.step_dec, c.dir_from_ram};
                    default:   o.read_data = '0;
                endcase
            FUNC_WRITE:
                case (r.reg_select)
                    SEL_BASE:
                        c.base = r.write_data[23:0];
                    SEL_BLOCK:
                    begin
                        c.block_size  = r.write_data[15:0];
                        c.block_count = r.write_data[31:16];
                    end
                    SEL_CTRL:
                    begin
                        sm = r.write_data[10:9];
                        // Reserved sync mode: drop the whole write and flag it
                        if (sm == SYNC_RESERVED)
                            o.sync_error = 1'b1;
                        else
                        begin
                            c.dir_from_ram = r.write_data[0];
                            c.step_dec     = r.write_data[1];
                            c.chop         = r.write_data[8];
                            c.sync_mode    = sm;
                            c.dma_window   = r.write_data[18:16];
                            c.cpu_window   = r.write_data[22:20];
                            c.enable       = r.write_data[24];
                            c.trigger      = r.write_data[28];
                            c.spare        = r.write_data[30:29];
                        end
                    end
                    default: ;
                endcase
            FUNC_DONE:
            begin
                c.enable  = 1'b0;
                c.trigger = 1'b0;
            end
            default: ;
        endcase
        chan_regs[r.channel] = c;
        o.active = c.enable && (c.sync_mode != SYNC_MANUAL || c.trigger);
        case (c.sync_mode)
            SYNC_MANUAL:  o.transfer_size = {16'h0000, c.block_size};
            SYNC_REQUEST: o.transfer_size = {16'h0000, c.block_size} *
                                            {16'h0000, c.block_count};
            SYNC_LINKED:  o.size_unknown = 1'b1;
            default:      o.transfer_size = '0;
        endcase
        return o;
    endfunction

    task automatic queue_request(input logic [FUNC_W-1:0] func,
                                 input logic [CHANNEL_W-1:0] channel,
                                 input logic [SEL_W-1:0] sel,
                                 input logic [DATA_W-1:0] data,
                                 input idle_mode_t mode);
        pending_req_t p;
        p.mode = mode;
        p.req = '{fill: 1'b0, write_data: data, reg_select: sel, channel: channel, func: func};
        pending_reqs.push_back(p);
    endtask

    // Driver: present the next request at the falling edge, hold it until taken.
    // The idle chance follows the mode of the request waiting at the head.
    always @(negedge clk)
    begin : drive_requests
        pending_req_t nxt;
        int           idle_pct;
        if (rst_n && (!s_tvalid || req_fire))
        begin
            idle_pct = 0;
            if (pending_reqs.size() != 0)
                idle_pct = (pending_reqs[0].mode == MODE_SRC_IDLE) ? 52 :
                           (pending_reqs[0].mode == MODE_BOTH) ? 38 : 0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                s_tdata  <= nxt.req;
                s_tvalid <= 1'b1;
                cur_mode <= nxt.mode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver side: stall at random according to the mode of the latest request
    always @(negedge clk)
    begin : drive_ready
        int stall_pct;
        stall_pct = (cur_mode == MODE_SINK_STALL) ? 52 : (cur_mode == MODE_BOTH) ? 38 : 0;
        if (rst_n)
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: predict on every accepted request, check every accepted response
    always @(posedge clk)
    begin : watch_streams
        bus_resp_t got;
        bus_resp_t want;
        if (rst_n)
        begin
            req_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                want = apply_access(s_tdata);
                resp_expected.push_back(want);
                if (s_tdata.channel >= NUM_CH)
                    n_out_of_range++;
                if (want.sync_error)
                    n_sync_err++;
                case (s_tdata.func)
                    FUNC_READ:  n_reads++;
                    FUNC_WRITE: n_writes++;
                    FUNC_DONE:  n_done++;
                    default:    n_other++;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                n_responses++;
                if (resp_expected.size() == 0)
                    report_mismatch($sformatf("response %0d with no request outstanding",
                                              n_responses));
                else
                begin
                    want = resp_expected.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch($sformatf("resp %0d read_data %h, want %h",
                                                  n_responses, got.read_data,
                                                  want.read_data));
                    if (got.active !== want.active)
                        report_mismatch($sformatf("resp %0d active %b, want %b",
                                                  n_responses, got.active, want.active));
                    if (got.transfer_size !== want.transfer_size)
                        report_mismatch($sformatf("resp %0d transfer_size %h, want %h",
                                                  n_responses, got.transfer_size,
                                                  want.transfer_size));
                    if (got.size_unknown !== want.size_unknown)
                        report_mismatch($sformatf("resp %0d size_unknown %b, want %b",
                                                  n_responses, got.size_unknown,
                                                  want.size_unknown));
                    if (got.sync_error !== want.sync_error)
                        report_mismatch($sformatf("resp %0d sync_error %b, want %b",
                                                  n_responses, got.sync_error,
                                                  want.sync_error));
                    if (got.fill !== want.fill)
                        report_mismatch($sformatf("resp %0d fill bits %b not zero",
                                                  n_responses, got.fill));
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run with every stall pattern
    initial
    begin
        #4_000_000;
        $display("Timeout: %0d requests pending, %0d responses outstanding",
                 pending_reqs.size(), resp_expected.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        idle_mode_t  mode;
        logic [1:0]  func;
        logic [2:0]  channel;
        logic [1:0]  sel;
        logic [31:0] wd;
        int          pick;

        for (int i = 0; i < NUM_CH; i++)
            chan_regs[i] = '0;

        // Directed pass, no idling: reset values, field extremes and corner cases
        queue_request(FUNC_READ,  3'd0, SEL_BASE,  32'h0000_0000, MODE_STEADY);
        // Base keeps 24 bits only
        queue_request(FUNC_WRITE, 3'd0, SEL_BASE,  32'hFFFF_FFFF, MODE_STEADY);
        queue_request(FUNC_READ,  3'd0, SEL_BASE,  32'h0000_0000, MODE_STEADY);
        // Largest product in request mode, every control field at its top
        queue_request(FUNC_WRITE, 3'd1, SEL_BLOCK, 32'hFFFF_FFFF, MODE_STEADY);
        queue_request(FUNC_WRITE, 3'd1, SEL_CTRL,  32'hFFFF_FBFF, MODE_STEADY);
        queue_request(FUNC_READ,  3'd1, SEL_CTRL,  32'h0000_0000, MODE_STEADY);
        queue_request(FUNC_READ,  3'd1, SEL_BLOCK, 32'h0000_0000, MODE_STEADY);
        // Reserved sync mode must leave the channel untouched
        queue_request(FUNC_WRITE, 3'd1, SEL_CTRL,  32'hFFFF_FFFF, MODE_STEADY);
        queue_request(FUNC_READ,  3'd1, SEL_CTRL,  32'h0000_0000, MODE_STEADY);
        // Mark done ignores select and data
        queue_request(FUNC_DONE,  3'd1, SEL_UNUSED, 32'hFFFF_FFFF, MODE_STEADY);
        queue_request(FUNC_READ,  3'd1, SEL_CTRL,  32'h0000_0000, MODE_STEADY);
        // Linked list: active without trigger, size unknown
        queue_request(FUNC_WRITE, 3'd2, SEL_CTRL,  32'h0100_0400, MODE_STEADY);
        // Manual mode: enable alone is not enough, trigger makes it active
        queue_request(FUNC_WRITE, 3'd3, SEL_BLOCK, 32'h1234_0040, MODE_STEADY);
        queue_request(FUNC_WRITE, 3'd3, SEL_CTRL,  32'h0100_0000, MODE_STEADY);
        queue_request(FUNC_WRITE, 3'd3, SEL_CTRL,  32'h1100_0000, MODE_STEADY);
        queue_request(FUNC_UNUSED, 3'd3, SEL_CTRL, 32'hFFFF_FFFF, MODE_STEADY);
        // Unused register select: writes dropped, reads zero
        queue_request(FUNC_WRITE, 3'd4, SEL_UNUSED, 32'hFFFF_FFFF, MODE_STEADY);
        queue_request(FUNC_READ,  3'd4, SEL_UNUSED, 32'h0000_0000, MODE_STEADY);
        // Channel beyond the bank: no effect, all fields zero
        queue_request(FUNC_WRITE, 3'd7, SEL_CTRL,  32'hFFFF_FBFF, MODE_STEADY);
        queue_request(FUNC_READ,  3'd7, SEL_CTRL,  32'h0000_0000, MODE_STEADY);
        queue_request(FUNC_WRITE, 3'd6, SEL_BLOCK, 32'h0000_0000, MODE_STEADY);
        queue_request(FUNC_WRITE, 3'd6, SEL_CTRL,  32'h0000_0200, MODE_STEADY);
        queue_request(FUNC_READ,  3'd6, SEL_BLOCK, 32'h0000_0000, MODE_STEADY);

        // Random pass in four idle phases of near-equal length
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            mode = idle_mode_t'((i * 4) / RANDOM_REQUESTS);
            pick = $urandom_range(99);
            func = (pick < 35) ? FUNC_READ : (pick < 75) ? FUNC_WRITE :
                   (pick < 90) ? FUNC_DONE : FUNC_UNUSED;
            channel = ($urandom_range(99) < 6) ? 3'd7 : 3'($urandom_range(NUM_CH - 1));
            pick = $urandom_range(99);
            sel = (pick < 30) ? SEL_BASE : (pick < 60) ? SEL_BLOCK :
                  (pick < 92) ? SEL_CTRL : SEL_UNUSED;
            wd = $urandom;
            // Keep most control writes legal so the channels reach every mode
            if ($urandom_range(99) >= 15)
                wd[10:9] = 2'($urandom_range(2));
            queue_request(func, channel, sel, wd, mode);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || resp_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d reads, %0d writes, %0d done, %0d unused func",
                 n_reads + n_writes + n_done + n_other, n_reads, n_writes, n_done, n_other);
        $display("Saw %0d reserved sync writes and %0d out-of-range channel accesses",
                 n_sync_err, n_out_of_range);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
design/dcrb_pkg.sv
design/dcrb_store.sv
design/dcrb_update.sv
design/dma_channel_register_bank_core.sv
dv/tb_top.sv
